FILE: rtl/gsc_pkg.sv
// Shared constants for the Gray-Scott cell update pipeline.
`default_nettype none

package gsc_pkg;

  // default number of fraction bits of the fixed-point formats
  localparam int FRAC_BITS_DEF = 16;

  // number of input fields: centre and four neighbors for each of the two species
  localparam int NUM_FIELDS = 10;

  // guard bits above FRAC_BITS for the intermediate values
  localparam int LAP_EXTRA    = 4;   // raw five-point sum, signed
  localparam int SCALED_EXTRA = 8;   // Laplacian after spacing scale, signed
  localparam int DELTA_EXTRA  = 10;  // rate of change per species, signed

  // configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_TIME_STEP      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIFFUSION_U    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DIFFUSION_V    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FEED_RATE      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KILL_RATE      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_INV_SPACING_SQ = 3'd5;

endpackage

`default_nettype wire

FILE: rtl/gsc_front.sv
// Front stages: five-point sums, spacing scale and reaction products.
`default_nettype none

module gsc_front #(
  parameter int FRAC_BITS = gsc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         in_valid,
  output logic                                              in_ready,
  input  wire logic [gsc_pkg::NUM_FIELDS*(FRAC_BITS+1)-1:0] in_data,
  input  wire logic [FRAC_BITS+3:0]                         inv_spacing_sq,
  input  wire logic [FRAC_BITS-1:0]                         feed_rate,
  input  wire logic [FRAC_BITS-1:0]                         kill_rate,
  output logic                                              out_valid,
  input  wire logic                                         out_ready,
  output logic signed [FRAC_BITS+gsc_pkg::SCALED_EXTRA-1:0] lap_u,
  output logic signed [FRAC_BITS+gsc_pkg::SCALED_EXTRA-1:0] lap_v,
  output logic [FRAC_BITS+2:0]                              uvv,
  output logic signed [FRAC_BITS+1:0]                       feed_term,
  output logic [FRAC_BITS+1:0]                              fk_v,
  output logic [FRAC_BITS:0]                                u_val,
  output logic [FRAC_BITS:0]                                v_val
);
  import gsc_pkg::*;

  localparam int FB  = FRAC_BITS;
  localparam int VW  = FB + 1;
  localparam int LW  = FB + LAP_EXTRA;
  localparam int SW  = FB + SCALED_EXTRA;
  localparam int OW  = FB + 2;
  localparam logic [OW-1:0] ONE = OW'(1) << FB;

  logic [VW-1:0] uc, un, us, uw, ue, vc, vn, vs, vw, ve;

  assign uc = in_data[0*VW +: VW];
  assign un = in_data[1*VW +: VW];
  assign us = in_data[2*VW +: VW];
  assign uw = in_data[3*VW +: VW];
  assign ue = in_data[4*VW +: VW];
  assign vc = in_data[5*VW +: VW];
  assign vn = in_data[6*VW +: VW];
  assign vs = in_data[7*VW +: VW];
  assign vw = in_data[8*VW +: VW];
  assign ve = in_data[9*VW +: VW];

  // stage 1: raw sums and first-level products
  logic signed [LW-1:0]     sum_u, sum_v;
  logic [2*VW-1:0]          uv_prod;
  logic signed [OW-1:0]     one_minus_u;
  logic signed [FB+OW:0]    feed_prod;
  logic [FB:0]              fk;
  logic [FB+VW:0]           fkv_prod;

  assign sum_u = $signed(LW'(un)) + $signed(LW'(us)) + $signed(LW'(uw)) + $signed(LW'(ue))
               - $signed(LW'({uc, 2'b00}));
  assign sum_v = $signed(LW'(vn)) + $signed(LW'(vs)) + $signed(LW'(vw)) + $signed(LW'(ve))
               - $signed(LW'({vc, 2'b00}));
  assign uv_prod     = uc * vc;
  assign one_minus_u = $signed(ONE) - $signed(OW'(uc));
  assign feed_prod   = $signed({1'b0, feed_rate}) * one_minus_u;
  assign fk          = {1'b0, feed_rate} + {1'b0, kill_rate};
  assign fkv_prod    = fk * vc;

  logic                 s1_vld;
  logic signed [LW-1:0] s1_sum_u, s1_sum_v;
  logic [VW:0]          s1_uv;
  logic signed [OW-1:0] s1_feed;
  logic [OW-1:0]        s1_fkv;
  logic [VW-1:0]        s1_u, s1_v;
  logic                 en1, en2;

  assign en2      = !out_valid || out_ready;
  assign en1      = !s1_vld || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en1) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_sum_u <= sum_u;
      s1_sum_v <= sum_v;
      s1_uv    <= uv_prod[2*VW-1:FB];
      s1_feed  <= $signed(feed_prod[FB+OW-1:FB]);
      s1_fkv   <= fkv_prod[FB+VW:FB];
      s1_u     <= uc;
      s1_v     <= vc;
    end
  end

  // stage 2: spacing scale and the second factor of v
  logic signed [LW+FB+4:0] lapu_prod, lapv_prod;
  logic [VW+VW:0]          uvv_prod;

  assign lapu_prod = s1_sum_u * $signed({1'b0, inv_spacing_sq});
  assign lapv_prod = s1_sum_v * $signed({1'b0, inv_spacing_sq});
  assign uvv_prod  = s1_uv * s1_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en2) begin
      out_valid <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      lap_u     <= $signed(lapu_prod[FB+SW-1:FB]);
      lap_v     <= $signed(lapv_prod[FB+SW-1:FB]);
      uvv       <= uvv_prod[FB+FB+2:FB];
      feed_term <= s1_feed;
      fk_v      <= s1_fkv;
      u_val     <= s1_u;
      v_val     <= s1_v;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gsc_rates.sv
// Middle stages: diffusion scale and the per-species rate of change.
`default_nettype none

module gsc_rates #(
  parameter int FRAC_BITS = gsc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         in_valid,
  output logic                                              in_ready,
  input  wire logic signed [FRAC_BITS+gsc_pkg::SCALED_EXTRA-1:0] lap_u,
  input  wire logic signed [FRAC_BITS+gsc_pkg::SCALED_EXTRA-1:0] lap_v,
  input  wire logic [FRAC_BITS+2:0]                         uvv,
  input  wire logic signed [FRAC_BITS+1:0]                  feed_term,
  input  wire logic [FRAC_BITS+1:0]                         fk_v,
  input  wire logic [FRAC_BITS:0]                           u_val,
  input  wire logic [FRAC_BITS:0]                           v_val,
  input  wire logic [FRAC_BITS-1:0]                         diffusion_u,
  input  wire logic [FRAC_BITS-1:0]                         diffusion_v,
  output logic                                              out_valid,
  input  wire logic                                         out_ready,
  output logic signed [FRAC_BITS+gsc_pkg::DELTA_EXTRA-1:0]  delta_u,
  output logic signed [FRAC_BITS+gsc_pkg::DELTA_EXTRA-1:0]  delta_v,
  output logic [FRAC_BITS:0]                                u_out,
  output logic [FRAC_BITS:0]                                v_out
);
  import gsc_pkg::*;

  localparam int FB = FRAC_BITS;
  localparam int VW = FB + 1;
  localparam int SW = FB + SCALED_EXTRA;
  localparam int DW = FB + DELTA_EXTRA;

  // stage A: diffusion coefficient times Laplacian
  logic signed [SW+FB:0] du_prod, dv_prod;

  assign du_prod = $signed({1'b0, diffusion_u}) * lap_u;
  assign dv_prod = $signed({1'b0, diffusion_v}) * lap_v;

  logic                 sa_vld;
  logic signed [SW-1:0] sa_dlu, sa_dlv;
  logic [FB+2:0]        sa_uvv;
  logic signed [FB+1:0] sa_feed;
  logic [FB+1:0]        sa_fkv;
  logic [VW-1:0]        sa_u, sa_v;
  logic                 ena, enb;

  assign enb      = !out_valid || out_ready;
  assign ena      = !sa_vld || enb;
  assign in_ready = ena;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_vld <= 1'b0;
    end else if (ena) begin
      sa_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      sa_dlu  <= $signed(du_prod[FB+SW-1:FB]);
      sa_dlv  <= $signed(dv_prod[FB+SW-1:FB]);
      sa_uvv  <= uvv;
      sa_feed <= feed_term;
      sa_fkv  <= fk_v;
      sa_u    <= u_val;
      sa_v    <= v_val;
    end
  end

  // stage B: combine diffusion, reaction and feed/kill terms
  logic signed [DW-1:0] du_sum, dv_sum;

  assign du_sum = DW'(sa_dlu) - $signed(DW'(sa_uvv)) + DW'(sa_feed);
  assign dv_sum = DW'(sa_dlv) + $signed(DW'(sa_uvv)) - $signed(DW'(sa_fkv));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (enb) begin
      out_valid <= sa_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (enb) begin
      delta_u <= du_sum;
      delta_v <= dv_sum;
      u_out   <= sa_u;
      v_out   <= sa_v;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gsc_integrate.sv
// Back stages: time step scale, Euler add and output clamps.
`default_nettype none

module gsc_integrate #(
  parameter int FRAC_BITS = gsc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        in_valid,
  output logic                                             in_ready,
  input  wire logic signed [FRAC_BITS+gsc_pkg::DELTA_EXTRA-1:0] delta_u,
  input  wire logic signed [FRAC_BITS+gsc_pkg::DELTA_EXTRA-1:0] delta_v,
  input  wire logic [FRAC_BITS:0]                          u_val,
  input  wire logic [FRAC_BITS:0]                          v_val,
  input  wire logic [FRAC_BITS-1:0]                        time_step,
  output logic                                             out_valid,
  input  wire logic                                        out_ready,
  output logic [FRAC_BITS:0]                               u_next,
  output logic [FRAC_BITS:0]                               v_next
);
  import gsc_pkg::*;

  localparam int FB = FRAC_BITS;
  localparam int VW = FB + 1;
  localparam int DW = FB + DELTA_EXTRA;
  localparam int AW = DW + 1;
  localparam logic [VW-1:0] U_LIMIT = VW'(3) << (FB - 1);
  localparam logic [VW-1:0] V_LIMIT = VW'(1) << FB;

  // stage A: scale each rate by dt
  logic signed [DW+FB:0] tu_prod, tv_prod;

  assign tu_prod = $signed({1'b0, time_step}) * delta_u;
  assign tv_prod = $signed({1'b0, time_step}) * delta_v;

  logic                 sa_vld;
  logic signed [DW-1:0] sa_tu, sa_tv;
  logic [VW-1:0]        sa_u, sa_v;
  logic                 ena, enb;

  assign enb      = !out_valid || out_ready;
  assign ena      = !sa_vld || enb;
  assign in_ready = ena;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_vld <= 1'b0;
    end else if (ena) begin
      sa_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      sa_tu <= $signed(tu_prod[FB+DW-1:FB]);
      sa_tv <= $signed(tv_prod[FB+DW-1:FB]);
      sa_u  <= u_val;
      sa_v  <= v_val;
    end
  end

  // stage B: add to the old value and clamp
  logic signed [AW-1:0] su, sv;
  logic [VW-1:0]        u_clamp, v_clamp;

  assign su = $signed(AW'(sa_u)) + AW'(sa_tu);
  assign sv = $signed(AW'(sa_v)) + AW'(sa_tv);

  always_comb begin
    if (su < 0) begin
      u_clamp = '0;
    end else if (su > $signed(AW'(U_LIMIT))) begin
      u_clamp = U_LIMIT;
    end else begin
      u_clamp = su[VW-1:0];
    end
    if (sv < 0) begin
      v_clamp = '0;
    end else if (sv > $signed(AW'(V_LIMIT))) begin
      v_clamp = V_LIMIT;
    end else begin
      v_clamp = sv[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (enb) begin
      out_valid <= sa_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (enb) begin
      u_next <= u_clamp;
      v_next <= v_clamp;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gray_scott_cell_update_core.sv
// Top level of the Gray-Scott cell update: config registers and the six-stage pipeline.
`default_nettype none

// One explicit Euler step of Gray-Scott reaction-diffusion for one grid cell.
// Each request on the slave stream carries the centre and four neighbor values
// of species u and v (unsigned Q1.FRAC_BITS); each result on the master stream
// carries the updated u (clamped to 0..1.5) and v (clamped to 0..1.0). The
// block takes one request per clock cycle unless the master side stalls. Two
// stages form the five-point sums, the spacing scale and the u*v*v product,
// two stages apply the diffusion rates and sum the terms, and two stages
// scale by dt, add and clamp. Each stage holds one request, so a stalled
// master side backs up stage by stage without dropping or repeating a
// result, and bubbles close up. Coefficients are written through the plain
// write port (index 0 dt, 1 Du, 2 Dv, 3 F, 4 k, 5 inverse squared spacing);
// write them only while no request is in flight. Unknown indexes are ignored.

module gray_scott_cell_update_core #(
  parameter int FRAC_BITS = gsc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  // u_center, u_north, u_south, u_west, u_east, v_center, v_north, v_south,
  // v_west, v_east, then zero fill to whole bytes
  input  wire logic [((gsc_pkg::NUM_FIELDS*(FRAC_BITS+1)+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic                                     s_axis_tvalid,
  output logic                                          s_axis_tready,
  // u_next, v_next, then zero fill to whole bytes
  output logic [((2*(FRAC_BITS+1)+7)/8)*8-1:0]          m_axis_tdata,
  output logic                                          m_axis_tvalid,
  input  wire logic                                     m_axis_tready,
  input  wire logic                                     cfg_wen,
  input  wire logic [gsc_pkg::REG_IDX_W-1:0]            cfg_index,
  input  wire logic [FRAC_BITS+3:0]                     cfg_data
);
  import gsc_pkg::*;

  localparam int FB      = FRAC_BITS;
  localparam int VW      = FB + 1;
  localparam int IN_BITS = NUM_FIELDS * VW;
  localparam int OUT_W   = ((2 * VW + 7) / 8) * 8;
  localparam int SW      = FB + SCALED_EXTRA;
  localparam int DW      = FB + DELTA_EXTRA;

  // reset values: 0.1, 0.20, 0.10, 0.026, 0.053 and 1.0, rounded to nearest
  localparam int ONE_I        = 1 << FB;
  localparam int TIME_STEP_RV = (ONE_I + 5) / 10;
  localparam int DIFF_U_RV    = (ONE_I * 2 + 5) / 10;
  localparam int DIFF_V_RV    = (ONE_I + 5) / 10;
  localparam int FEED_RV      = (ONE_I * 26 + 500) / 1000;
  localparam int KILL_RV      = (ONE_I * 53 + 500) / 1000;

  // coefficient registers
  logic [FB-1:0] time_step;
  logic [FB-1:0] diffusion_u;
  logic [FB-1:0] diffusion_v;
  logic [FB-1:0] feed_rate;
  logic [FB-1:0] kill_rate;
  logic [FB+3:0] inv_spacing_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step      <= FB'(TIME_STEP_RV);
      diffusion_u    <= FB'(DIFF_U_RV);
      diffusion_v    <= FB'(DIFF_V_RV);
      feed_rate      <= FB'(FEED_RV);
      kill_rate      <= FB'(KILL_RV);
      inv_spacing_sq <= (FB+4)'(ONE_I);
    end else if (cfg_wen) begin
      // take the low bits that fit the register; drop writes to unknown indexes
      case (cfg_index)
        REG_TIME_STEP:      time_step      <= cfg_data[FB-1:0];
        REG_DIFFUSION_U:    diffusion_u    <= cfg_data[FB-1:0];
        REG_DIFFUSION_V:    diffusion_v    <= cfg_data[FB-1:0];
        REG_FEED_RATE:      feed_rate      <= cfg_data[FB-1:0];
        REG_KILL_RATE:      kill_rate      <= cfg_data[FB-1:0];
        REG_INV_SPACING_SQ: inv_spacing_sq <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front -> rates
  logic                 f_valid, f_ready;
  logic signed [SW-1:0] f_lap_u, f_lap_v;
  logic [FB+2:0]        f_uvv;
  logic signed [FB+1:0] f_feed;
  logic [FB+1:0]        f_fkv;
  logic [VW-1:0]        f_u, f_v;

  gsc_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_data        (s_axis_tdata[IN_BITS-1:0]),
    .inv_spacing_sq (inv_spacing_sq),
    .feed_rate      (feed_rate),
    .kill_rate      (kill_rate),
    .out_valid      (f_valid),
    .out_ready      (f_ready),
    .lap_u          (f_lap_u),
    .lap_v          (f_lap_v),
    .uvv            (f_uvv),
    .feed_term      (f_feed),
    .fk_v           (f_fkv),
    .u_val          (f_u),
    .v_val          (f_v)
  );

  // rates -> integrate
  logic                 r_valid, r_ready;
  logic signed [DW-1:0] r_du, r_dv;
  logic [VW-1:0]        r_u, r_v;

  gsc_rates #(
    .FRAC_BITS(FRAC_BITS)
  ) u_rates (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (f_valid),
    .in_ready    (f_ready),
    .lap_u       (f_lap_u),
    .lap_v       (f_lap_v),
    .uvv         (f_uvv),
    .feed_term   (f_feed),
    .fk_v        (f_fkv),
    .u_val       (f_u),
    .v_val       (f_v),
    .diffusion_u (diffusion_u),
    .diffusion_v (diffusion_v),
    .out_valid   (r_valid),
    .out_ready   (r_ready),
    .delta_u     (r_du),
    .delta_v     (r_dv),
    .u_out       (r_u),
    .v_out       (r_v)
  );

  // last stage is the output register
  logic [VW-1:0] u_next, v_next;

  gsc_integrate #(
    .FRAC_BITS(FRAC_BITS)
  ) u_integrate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .in_ready  (r_ready),
    .delta_u   (r_du),
    .delta_v   (r_dv),
    .u_val     (r_u),
    .v_val     (r_v),
    .time_step (time_step),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .u_next    (u_next),
    .v_next    (v_next)
  );

  assign m_axis_tdata = OUT_W'({v_next, u_next});

endmodule

`default_nettype wire
